@@ rtl/apr_pkg.sv @@
// Shared types, constants and helpers for the axis point rotator.
package apr_pkg;

    // Default geometry
    localparam int COORD_WIDTH_DEF = 32;
    localparam int ANGLE_WIDTH_DEF = 16;

    // Rotation axis selector
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    // Fixed-point widths of the sine/cosine datapath
    localparam int FRAC_BITS = 30;   // Q30 fraction
    localparam int T_W       = 31;   // Q30 term, up to and including 1.0
    localparam int U_W       = 31;   // reduced angle in Q30, below pi/2
    localparam int U2_W      = 32;   // angle squared in Q30
    localparam int N_W       = 32;   // Taylor numerator after the Q30 product
    localparam int RECIP_W   = 32;   // reciprocal of a term divisor
    localparam int DIV_W     = 8;    // term divisor
    localparam int F_W       = 32;   // signed sine/cosine factor

    localparam logic [T_W-1:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [U_W-1:0] HALF_PI_Q30 = 31'd1686629713;

    // Nested series terms, innermost first
    localparam int TAYLOR_TERMS = 7;

    localparam logic [DIV_W-1:0] SIN_DIV [TAYLOR_TERMS] = '{
        8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
    };
    localparam logic [DIV_W-1:0] COS_DIV [TAYLOR_TERMS] = '{
        8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
    };

    // floor(2^32 / d): quotient estimate is low by at most one
    localparam logic [RECIP_W-1:0] SIN_RECIP [TAYLOR_TERMS] = '{
        32'((64'd1 << 32) / 64'd210), 32'((64'd1 << 32) / 64'd156),
        32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd72),
        32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd20),
        32'((64'd1 << 32) / 64'd6)
    };
    localparam logic [RECIP_W-1:0] COS_RECIP [TAYLOR_TERMS] = '{
        32'((64'd1 << 32) / 64'd182), 32'((64'd1 << 32) / 64'd132),
        32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd56),
        32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd12),
        32'((64'd1 << 32) / 64'd2)
    };

    // Pipeline stage numbers
    localparam int ST_U   = 0;
    localparam int ST_U2  = 1;
    localparam int ST_TAY = 2;
    localparam int ST_SU  = ST_TAY + 3 * TAYLOR_TERMS;
    localparam int ST_SC  = ST_SU + 1;
    localparam int ST_SEL = ST_SC + 1;
    localparam int ST_MUL = ST_SEL + 1;
    localparam int ST_SUM = ST_MUL + 1;
    localparam int N_ST   = ST_SUM + 1;

    // Correct the quotient estimate by one, then form 1 - p clamped at zero
    function automatic logic [T_W-1:0] term_next(
        input logic [N_W-1:0]   n,
        input logic [N_W-1:0]   q0,
        input logic [DIV_W-1:0] d
    );
        logic [N_W+DIV_W-1:0] qd;
        logic [N_W+DIV_W-1:0] rem;
        logic [N_W:0]         q;
        qd  = {{DIV_W{1'b0}}, q0} * {{N_W{1'b0}}, d};
        rem = {{DIV_W{1'b0}}, n} - qd;
        q   = {1'b0, q0} + (N_W + 1)'(rem >= {{N_W{1'b0}}, d});
        if (q > (N_W + 1)'(Q30_ONE)) begin
            term_next = '0;
        end else begin
            term_next = T_W'((N_W + 1)'(Q30_ONE) - q);
        end
    endfunction

endpackage

@@ rtl/axis_point_rotator_unit.sv @@
// Streaming rotator of a 3D point about a principal axis by a per-item angle.

// Each item carries an axis, an angle as a fraction of a full turn and a Q16.16
// point; the two coordinates in the plane of rotation are rotated, rounded to
// nearest and saturated, the third passes through, and axis code 3 passes the
// whole point unchanged. The block takes one item per clock while the skid
// entry is empty, and a result passes through two angle-reduction stages, 21
// stages for the seven nested sine/cosine series terms (multiply, reciprocal
// multiply, quotient correction each), one stage for the final sine product,
// one for the quadrant map, one for operand selection, one for partial
// products, one for the rounded sum, then the output register. An output
// register and one skid entry hold results while m_tready is low; the pipeline
// freezes only once the skid entry is full.
module axis_point_rotator_unit
    import apr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    localparam int IN_W  = ((ANGLE_WIDTH + 3 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // turn_angle, point_x, point_y, point_z
    input  logic [IN_W-1:0]  s_tdata,
    // req_type
    input  logic [1:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // rotated_x, rotated_y, rotated_z
    output logic [OUT_W-1:0] m_tdata
);

    localparam int CW    = COORD_WIDTH;
    localparam int RW    = ANGLE_WIDTH - 2;
    localparam int LO_W  = CW / 2;
    localparam int HI_W  = CW - LO_W;
    localparam int SUM_W = CW + F_W + 1;
    localparam int RND_W = SUM_W - FRAC_BITS;
    localparam int OFS_X = ANGLE_WIDTH;
    localparam int OFS_Y = ANGLE_WIDTH + CW;
    localparam int OFS_Z = ANGLE_WIDTH + 2 * CW;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

    // Saturate a rounded sum to the coordinate range
    function automatic logic signed [CW-1:0] sat_coord(input logic signed [RND_W-1:0] v);
        logic fits;
        fits = (&v[RND_W-1:CW-1]) || !(|v[RND_W-1:CW-1]);
        if (fits) begin
            sat_coord = v[CW-1:0];
        end else if (v[RND_W-1]) begin
            sat_coord = {1'b1, {(CW-1){1'b0}}};
        end else begin
            sat_coord = {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    // Flow control
    logic en;
    logic o_valid_reg;
    logic k_valid_reg;
    logic [3*CW-1:0] o_data_reg;
    logic [3*CW-1:0] k_data_reg;
    logic [3*CW-1:0] res;

    // Side data traveling with every stage
    logic                 valid_reg [N_ST];
    logic [1:0]           axis_reg  [N_ST];
    logic [1:0]           quad_reg  [N_ST];
    logic signed [CW-1:0] x_reg     [N_ST];
    logic signed [CW-1:0] y_reg     [N_ST];
    logic signed [CW-1:0] z_reg     [N_ST];

    // Angle reduction
    logic [RW+U_W-1:0]    u_prod;
    logic [U_W-1:0]       u_reg  [ST_SU];
    logic [2*U_W-1:0]     u2_prod;
    logic [U2_W-1:0]      u2_reg [ST_U2:ST_TAY+3*(TAYLOR_TERMS-1)-1];

    // Series terms
    logic [T_W-1:0]       ts_in     [TAYLOR_TERMS];
    logic [T_W-1:0]       tc_in     [TAYLOR_TERMS];
    logic [U2_W+T_W-1:0]  sq_s      [TAYLOR_TERMS];
    logic [U2_W+T_W-1:0]  sq_c      [TAYLOR_TERMS];
    logic [N_W+RECIP_W-1:0] rp_s    [TAYLOR_TERMS];
    logic [N_W+RECIP_W-1:0] rp_c    [TAYLOR_TERMS];
    logic [N_W-1:0]       na_s_reg  [TAYLOR_TERMS];
    logic [N_W-1:0]       na_c_reg  [TAYLOR_TERMS];
    logic [N_W-1:0]       nb_s_reg  [TAYLOR_TERMS];
    logic [N_W-1:0]       nb_c_reg  [TAYLOR_TERMS];
    logic [N_W-1:0]       q0_s_reg  [TAYLOR_TERMS];
    logic [N_W-1:0]       q0_c_reg  [TAYLOR_TERMS];
    logic [T_W-1:0]       ts_reg    [TAYLOR_TERMS];
    logic [T_W-1:0]       tc_reg    [TAYLOR_TERMS];

    // Sine/cosine
    logic [U_W+T_W-1:0]   su_prod;
    logic [T_W-1:0]       su_reg;
    logic [T_W-1:0]       cu_reg;
    logic signed [F_W-1:0] su_s;
    logic signed [F_W-1:0] cu_s;
    logic signed [F_W-1:0] s_next;
    logic signed [F_W-1:0] c_next;
    logic signed [F_W-1:0] s_reg;
    logic signed [F_W-1:0] c_reg;

    // Two rotation lanes: lane 0 and lane 1
    logic signed [CW-1:0]  opa_next [2];
    logic signed [CW-1:0]  opb_next [2];
    logic signed [F_W-1:0] fa_next  [2];
    logic signed [F_W-1:0] fb_next  [2];
    logic signed [CW-1:0]  opa_reg  [2];
    logic signed [CW-1:0]  opb_reg  [2];
    logic signed [F_W-1:0] fa_reg   [2];
    logic signed [F_W-1:0] fb_reg   [2];
    logic signed [LO_W+F_W:0]   alo_p_reg [2];
    logic signed [HI_W+F_W-1:0] ahi_p_reg [2];
    logic signed [LO_W+F_W:0]   blo_p_reg [2];
    logic signed [HI_W+F_W-1:0] bhi_p_reg [2];
    logic signed [SUM_W-1:0]    sum_next  [2];
    logic signed [RND_W-1:0]    rnd_reg   [2];
    logic signed [CW-1:0]       lane_sat  [2];

    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
    logic signed [CW-1:0] rz;

    assign en       = !k_valid_reg;
    assign s_tready = en;

    // Advance the valid line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N_ST; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= s_tvalid;
            for (int i = 1; i < N_ST; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // Angle reduction and series products
    always_comb begin
        u_prod  = {{U_W{1'b0}}, s_tdata[RW-1:0]} * {{RW{1'b0}}, HALF_PI_Q30};
        u2_prod = {{U_W{1'b0}}, u_reg[ST_U]} * {{U_W{1'b0}}, u_reg[ST_U]};
        ts_in[0] = Q30_ONE;
        tc_in[0] = Q30_ONE;
        for (int j = 1; j < TAYLOR_TERMS; j++) begin
            ts_in[j] = ts_reg[j-1];
            tc_in[j] = tc_reg[j-1];
        end
        for (int j = 0; j < TAYLOR_TERMS; j++) begin
            sq_s[j] = {{T_W{1'b0}}, u2_reg[ST_U2+3*j]} * {{U2_W{1'b0}}, ts_in[j]};
            sq_c[j] = {{T_W{1'b0}}, u2_reg[ST_U2+3*j]} * {{U2_W{1'b0}}, tc_in[j]};
            rp_s[j] = {{RECIP_W{1'b0}}, na_s_reg[j]} * {{N_W{1'b0}}, SIN_RECIP[j]};
            rp_c[j] = {{RECIP_W{1'b0}}, na_c_reg[j]} * {{N_W{1'b0}}, COS_RECIP[j]};
        end
        su_prod = {{T_W{1'b0}}, u_reg[ST_SU-1]} * {{U_W{1'b0}}, ts_reg[TAYLOR_TERMS-1]};
    end

    // Map the quadrant onto sine and cosine
    always_comb begin
        su_s = $signed(F_W'(su_reg));
        cu_s = $signed(F_W'(cu_reg));
        case (quad_reg[ST_SU])
            2'd0: begin
                s_next = su_s;
                c_next = cu_s;
            end
            2'd1: begin
                s_next = cu_s;
                c_next = -su_s;
            end
            2'd2: begin
                s_next = -su_s;
                c_next = -cu_s;
            end
            default: begin
                s_next = -cu_s;
                c_next = su_s;
            end
        endcase
    end

    // Pick lane operands for the selected axis
    always_comb begin
        case (axis_t'(axis_reg[ST_SC]))
            AXIS_X: begin
                opa_next[0] = y_reg[ST_SC]; fa_next[0] = c_reg;
                opb_next[0] = z_reg[ST_SC]; fb_next[0] = s_reg;
                opa_next[1] = z_reg[ST_SC]; fa_next[1] = c_reg;
                opb_next[1] = y_reg[ST_SC]; fb_next[1] = -s_reg;
            end
            AXIS_Y: begin
                opa_next[0] = x_reg[ST_SC]; fa_next[0] = c_reg;
                opb_next[0] = z_reg[ST_SC]; fb_next[0] = -s_reg;
                opa_next[1] = x_reg[ST_SC]; fa_next[1] = s_reg;
                opb_next[1] = z_reg[ST_SC]; fb_next[1] = c_reg;
            end
            AXIS_Z: begin
                opa_next[0] = x_reg[ST_SC]; fa_next[0] = c_reg;
                opb_next[0] = y_reg[ST_SC]; fb_next[0] = s_reg;
                opa_next[1] = y_reg[ST_SC]; fa_next[1] = c_reg;
                opb_next[1] = x_reg[ST_SC]; fb_next[1] = -s_reg;
            end
            default: begin
                opa_next[0] = '0; fa_next[0] = '0;
                opb_next[0] = '0; fb_next[0] = '0;
                opa_next[1] = '0; fa_next[1] = '0;
                opb_next[1] = '0; fb_next[1] = '0;
            end
        endcase
    end

    // Add the partial products with the rounding half
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            sum_next[l] = (SUM_W'(ahi_p_reg[l]) <<< LO_W) + SUM_W'(alo_p_reg[l])
                        + (SUM_W'(bhi_p_reg[l]) <<< LO_W) + SUM_W'(blo_p_reg[l])
                        + ROUND_HALF;
        end
    end

    // Advance the datapath
    always_ff @(posedge aclk) begin
        if (en) begin
            // side data
            axis_reg[0] <= s_tuser;
            quad_reg[0] <= s_tdata[ANGLE_WIDTH-1:RW];
            x_reg[0]    <= s_tdata[OFS_X+CW-1:OFS_X];
            y_reg[0]    <= s_tdata[OFS_Y+CW-1:OFS_Y];
            z_reg[0]    <= s_tdata[OFS_Z+CW-1:OFS_Z];
            for (int i = 1; i < N_ST; i++) begin
                axis_reg[i] <= axis_reg[i-1];
                quad_reg[i] <= quad_reg[i-1];
                x_reg[i]    <= x_reg[i-1];
                y_reg[i]    <= y_reg[i-1];
                z_reg[i]    <= z_reg[i-1];
            end

            // angle reduction
            u_reg[ST_U] <= u_prod[RW+U_W-1:RW];
            for (int i = 1; i < ST_SU; i++) begin
                u_reg[i] <= u_reg[i-1];
            end
            u2_reg[ST_U2] <= u2_prod[FRAC_BITS+U2_W-1:FRAC_BITS];
            for (int i = ST_U2 + 1; i < ST_TAY + 3 * (TAYLOR_TERMS - 1); i++) begin
                u2_reg[i] <= u2_reg[i-1];
            end

            // series terms: product, reciprocal, correction
            for (int j = 0; j < TAYLOR_TERMS; j++) begin
                na_s_reg[j] <= sq_s[j][FRAC_BITS+N_W-1:FRAC_BITS];
                na_c_reg[j] <= sq_c[j][FRAC_BITS+N_W-1:FRAC_BITS];
                nb_s_reg[j] <= na_s_reg[j];
                nb_c_reg[j] <= na_c_reg[j];
                q0_s_reg[j] <= rp_s[j][N_W+RECIP_W-1:RECIP_W];
                q0_c_reg[j] <= rp_c[j][N_W+RECIP_W-1:RECIP_W];
                ts_reg[j]   <= term_next(nb_s_reg[j], q0_s_reg[j], SIN_DIV[j]);
                tc_reg[j]   <= term_next(nb_c_reg[j], q0_c_reg[j], COS_DIV[j]);
            end

            // sine and cosine
            su_reg <= su_prod[FRAC_BITS+T_W-1:FRAC_BITS];
            cu_reg <= tc_reg[TAYLOR_TERMS-1];
            s_reg  <= s_next;
            c_reg  <= c_next;

            // lanes
            for (int l = 0; l < 2; l++) begin
                opa_reg[l]   <= opa_next[l];
                opb_reg[l]   <= opb_next[l];
                fa_reg[l]    <= fa_next[l];
                fb_reg[l]    <= fb_next[l];
                alo_p_reg[l] <= $signed({1'b0, opa_reg[l][LO_W-1:0]}) * fa_reg[l];
                ahi_p_reg[l] <= $signed(opa_reg[l][CW-1:LO_W]) * fa_reg[l];
                blo_p_reg[l] <= $signed({1'b0, opb_reg[l][LO_W-1:0]}) * fb_reg[l];
                bhi_p_reg[l] <= $signed(opb_reg[l][CW-1:LO_W]) * fb_reg[l];
                rnd_reg[l]   <= sum_next[l][SUM_W-1:FRAC_BITS];
            end
        end
    end

    // Saturate and place the lanes by axis
    always_comb begin
        lane_sat[0] = sat_coord(rnd_reg[0]);
        lane_sat[1] = sat_coord(rnd_reg[1]);
        rx = x_reg[ST_SUM];
        ry = y_reg[ST_SUM];
        rz = z_reg[ST_SUM];
        case (axis_t'(axis_reg[ST_SUM]))
            AXIS_X: begin
                ry = lane_sat[0];
                rz = lane_sat[1];
            end
            AXIS_Y: begin
                rx = lane_sat[0];
                rz = lane_sat[1];
            end
            AXIS_Z: begin
                rx = lane_sat[0];
                ry = lane_sat[1];
            end
            default: begin
                rx = x_reg[ST_SUM];
            end
        endcase
        res = {rz, ry, rx};
    end

    // Output register and skid entry: hold a result, drain the skid first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
            k_valid_reg <= 1'b0;
        end else if (k_valid_reg) begin
            if (m_tready) begin
                k_valid_reg <= 1'b0;
            end
        end else if (valid_reg[ST_SUM]) begin
            if (!o_valid_reg || m_tready) begin
                o_valid_reg <= 1'b1;
            end else begin
                k_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (k_valid_reg) begin
            if (m_tready) begin
                o_data_reg <= k_data_reg;
            end
        end else if (valid_reg[ST_SUM]) begin
            if (!o_valid_reg || m_tready) begin
                o_data_reg <= res;
            end else begin
                k_data_reg <= res;
            end
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = OUT_W'(o_data_reg);

endmodule
